// ===== rtl/bwu_pkg.sv =====
// ----------------------------------------------------------------------------
// bwu_pkg - barycentric weights unit package
// Request and response types, datapath widths and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bwu_pkg;

   // coordinate, weight and threshold widths
   localparam int COORD_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int THR_W = 16;

   // quotient dividend width: (|num| << 17) + |den| stays below 2^53
   localparam int QW = 53;
   // divisor width: 2*|uz| stays below 2^35
   localparam int DW = 35;

   // fixed weights of a degenerate triangle and saturation bounds (Q16.16)
   localparam logic signed [WEIGHT_W-1:0] ONE_Q16 = 32'sd65536;
   localparam logic signed [WEIGHT_W-1:0] NEG_ONE_Q16 = -32'sd65536;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
   } req_type;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight_a;
      logic signed [WEIGHT_W-1:0] weight_b;
      logic signed [WEIGHT_W-1:0] weight_c;
      logic                       degenerate;
   } rsp_type;

   // one divider lane operand set
   typedef struct packed {
      logic [QW-1:0] dividend;
      logic          neg;
   } lane_op_type;

endpackage

`default_nettype wire

// ===== rtl/barycentric_weights_unit.sv =====
// ----------------------------------------------------------------------------
// barycentric_weights_unit - barycentric weights of a point in a triangle
// Cross product setup, three pipelined dividers and Q16.16 saturation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | bwu_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_stall | bwu_pkg::rsp_type
//  csr     | in        | csr_write_en        | degenerate threshold, 16 bit
//
//  One request per cycle unless the response is stalled; 5 setup stages, 53 divider
//  stages (one quotient bit each) and the output register.
//  Reset clears all valid bits and sets the threshold to 3.
//  A stalled response freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module barycentric_weights_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire bwu_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output bwu_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_write_en,
   input  wire logic [bwu_pkg::THR_W-1:0] csr_write_data
);
   import bwu_pkg::*;

   logic              en;
   logic [THR_W-1:0]  thr_ff;
   logic              f_valid, f_degen;
   logic [DW-1:0]     f_div;
   lane_op_type       op_a, op_b, op_c;
   logic [QW-1:0]     q_a, q_b, q_c;
   logic              s_a, s_b, s_c;
   logic              v_ff [0:QW-1];
   logic              dg_ff [0:QW-1];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   // pipeline advances unless a finished response is held
   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(3);
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   bwu_front u_front (
      .clock(clock), .reset(reset), .en(en), .req_valid(req_valid),
      .req_data(req_data), .threshold(thr_ff), .valid(f_valid), .degen(f_degen),
      .divisor(f_div), .op_a(op_a), .op_b(op_b), .op_c(op_c)
   );

   bwu_div_lane u_div_a (
      .clock(clock), .en(en), .op(op_a), .divisor(f_div), .quotient(q_a), .neg(s_a)
   );
   bwu_div_lane u_div_b (
      .clock(clock), .en(en), .op(op_b), .divisor(f_div), .quotient(q_b), .neg(s_b)
   );
   bwu_div_lane u_div_c (
      .clock(clock), .en(en), .op(op_c), .divisor(f_div), .quotient(q_c), .neg(s_c)
   );

   // valid and degenerate flag alongside the dividers
   for (genvar k = 0; k < QW; k++) begin : g_tag
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= (k == 0) ? f_valid : v_ff[(k == 0) ? 0 : k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dg_ff[k] <= (k == 0) ? f_degen : dg_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // signed saturation of a rounded quotient magnitude
   function automatic logic signed [WEIGHT_W-1:0] sat_weight(logic [QW-1:0] q, logic s);
      logic signed [WEIGHT_W-1:0] w;
      if (s) begin
         w = (q > QW'(64'h8000_0000)) ? WEIGHT_MIN : -$signed(q[WEIGHT_W-1:0]);
      end else begin
         w = (q > QW'(64'h7FFF_FFFF)) ? WEIGHT_MAX : $signed(q[WEIGHT_W-1:0]);
      end
      return w;
   endfunction

   always_comb begin
      if (dg_ff[QW-1]) begin
         rsp_in.weight_a = NEG_ONE_Q16;
         rsp_in.weight_b = ONE_Q16;
         rsp_in.weight_c = ONE_Q16;
      end else begin
         rsp_in.weight_a = sat_weight(q_a, s_a);
         rsp_in.weight_b = sat_weight(q_b, s_b);
         rsp_in.weight_c = sat_weight(q_c, s_c);
      end
      rsp_in.degenerate = dg_ff[QW-1];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/bwu_front.sv =====
// ----------------------------------------------------------------------------
// bwu_front - edge vectors, cross product and divider operand setup
// Five register stages from the raw coordinates to the rounding dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      req_valid,
   input  wire bwu_pkg::req_type          req_data,
   input  wire logic [bwu_pkg::THR_W-1:0] threshold,
   output logic                           valid,
   output logic                           degen,
   output logic [bwu_pkg::DW-1:0]         divisor,
   output bwu_pkg::lane_op_type           op_a,
   output bwu_pkg::lane_op_type           op_b,
   output bwu_pkg::lane_op_type           op_c
);
   import bwu_pkg::*;

   logic [4:0] valid_ff;

   // stage 1: edge vectors
   logic signed [16:0] abx_ff, aby_ff, acx_ff, acy_ff, pax_ff, pay_ff;
   // stage 2: products
   logic signed [33:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   // stage 3: cross product
   logic signed [34:0] ux_ff, uy_ff, uz_ff;
   // stage 4: numerators, divisor magnitude, degenerate flag
   logic signed [35:0] na_ff, nb_ff, nc_ff;
   logic [33:0]        mag_ff;
   logic               den_neg_ff, degen4_ff;
   // stage 5: divider operands
   logic [DW-1:0]      div_ff;
   lane_op_type        opa_ff, opb_ff, opc_ff;
   logic               degen5_ff;

   logic signed [35:0] na_in;
   logic [33:0]        mag_in;
   logic [34:0]        absa, absb, absc;

   // numerator of weight A and divisor magnitude
   assign na_in = 36'(uz_ff) - 36'(ux_ff) - 36'(uy_ff);
   assign mag_in = uz_ff[34] ? 34'(-uz_ff) : 34'(uz_ff);

   // numerator magnitudes
   assign absa = na_ff[35] ? 35'(-na_ff) : 35'(na_ff);
   assign absb = nb_ff[35] ? 35'(-nb_ff) : 35'(nb_ff);
   assign absc = nc_ff[35] ? 35'(-nc_ff) : 35'(nc_ff);

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], req_valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (en) begin
         abx_ff <= 17'(req_data.bx) - 17'(req_data.ax);
         aby_ff <= 17'(req_data.by) - 17'(req_data.ay);
         acx_ff <= 17'(req_data.cx) - 17'(req_data.ax);
         acy_ff <= 17'(req_data.cy) - 17'(req_data.ay);
         pax_ff <= 17'(req_data.ax) - 17'(req_data.px);
         pay_ff <= 17'(req_data.ay) - 17'(req_data.py);

         m0_ff <= acx_ff * pay_ff;
         m1_ff <= pax_ff * acy_ff;
         m2_ff <= pax_ff * aby_ff;
         m3_ff <= abx_ff * pay_ff;
         m4_ff <= abx_ff * acy_ff;
         m5_ff <= acx_ff * aby_ff;

         ux_ff <= 35'(m0_ff) - 35'(m1_ff);
         uy_ff <= 35'(m2_ff) - 35'(m3_ff);
         uz_ff <= 35'(m4_ff) - 35'(m5_ff);

         na_ff <= na_in;
         nb_ff <= 36'(ux_ff);
         nc_ff <= 36'(uy_ff);
         mag_ff <= mag_in;
         den_neg_ff <= uz_ff[34];
         degen4_ff <= !(mag_in > 34'(threshold));

         // round to nearest: (2n + d) / (2d) with n = |num| << 16
         div_ff <= {mag_ff, 1'b0};
         opa_ff.dividend <= {1'b0, absa, 17'd0} + QW'(mag_ff);
         opb_ff.dividend <= {1'b0, absb, 17'd0} + QW'(mag_ff);
         opc_ff.dividend <= {1'b0, absc, 17'd0} + QW'(mag_ff);
         opa_ff.neg <= na_ff[35] ^ den_neg_ff;
         opb_ff.neg <= nb_ff[35] ^ den_neg_ff;
         opc_ff.neg <= nc_ff[35] ^ den_neg_ff;
         degen5_ff <= degen4_ff;
      end
   end

   assign valid = valid_ff[4];
   assign degen = degen5_ff;
   assign divisor = div_ff;
   assign op_a = opa_ff;
   assign op_b = opb_ff;
   assign op_c = opc_ff;

endmodule

`default_nettype wire

// ===== rtl/bwu_div_lane.sv =====
// ----------------------------------------------------------------------------
// bwu_div_lane - pipelined restoring divider
// One quotient bit per register stage, QW stages, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_div_lane (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire bwu_pkg::lane_op_type   op,
   input  wire logic [bwu_pkg::DW-1:0] divisor,
   output logic [bwu_pkg::QW-1:0]      quotient,
   output logic                        neg
);
   import bwu_pkg::*;

   logic [QW-1:0] n_ff [0:QW-1];
   logic [QW-1:0] q_ff [0:QW-1];
   logic [DW-1:0] r_ff [0:QW-1];
   logic [DW-1:0] d_ff [0:QW-1];
   logic          s_ff [0:QW-1];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [QW-1:0] n_prev, q_prev;
      logic [DW-1:0] r_prev, d_prev;
      logic          s_prev;
      logic [DW:0]   trial, diff;

      if (k == 0) begin : g_first
         assign n_prev = op.dividend;
         assign q_prev = '0;
         assign r_prev = '0;
         assign d_prev = divisor;
         assign s_prev = op.neg;
      end else begin : g_next
         assign n_prev = n_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign r_prev = r_ff[k-1];
         assign d_prev = d_ff[k-1];
         assign s_prev = s_ff[k-1];
      end

      // shift in the next dividend bit and try the subtract
      assign trial = {r_prev, n_prev[QW-1-k]};
      assign diff = trial - {1'b0, d_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            n_ff[k] <= n_prev;
            d_ff[k] <= d_prev;
            s_ff[k] <= s_prev;
            q_ff[k] <= {q_prev[QW-2:0], !diff[DW]};
            r_ff[k] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
         end
      end
   end

   assign quotient = q_ff[QW-1];
   assign neg = s_ff[QW-1];

endmodule

`default_nettype wire

// ===== rtl/bwu_checker.sv =====
// ----------------------------------------------------------------------------
// bwu_checker - port level checks for the barycentric weights unit
// Request and response hold, degenerate encoding, reset and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module bwu_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire bwu_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire bwu_pkg::rsp_type rsp_data
);
   import bwu_pkg::*;

   // a stalled request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // degenerate responses carry the fixed weights
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.weight_a == NEG_ONE_Q16 && rsp_data.weight_b == ONE_Q16 &&
         rsp_data.weight_c == ONE_Q16)
      else $error("degenerate response with wrong weights");

   // no response right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // requests are held off only by a blocked response
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without back pressure");

endmodule

bind barycentric_weights_unit bwu_checker u_bwu_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);

`default_nettype wire

// ===== dv/tb_barycentric_weights_unit.sv =====
// ----------------------------------------------------------------------------
// tb_barycentric_weights_unit - barycentric weights unit testbench
// Drives triangle/point requests with bursty timing against a stalling
// receiver, predicts Q16.16 weights with an exact rounded divide and checks
// every response in order. Threshold is reprogrammed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_barycentric_weights_unit;
   import bwu_pkg::*;

   localparam int PIPE_LAT = 59;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_en = 1'b0;
   logic [THR_W-1:0] csr_write_data = '0;

   logic [THR_W-1:0] area_thr;
   rsp_type weights_due[$];
   int n_errors = 0;
   int n_checked = 0;
   int n_degen = 0;
   int n_sent = 0;
   int burst_left = 0;

   barycentric_weights_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // (num << 16) / den rounded half away from zero, saturated to 32 bits
   function automatic logic signed [WEIGHT_W-1:0] q16_quotient(longint num, longint den);
      logic neg;
      longint unsigned n, d, q;
      neg = (num < 0) != (den < 0);
      n = longint'(num < 0 ? -num : num) << 16;
      d = den < 0 ? -den : den;
      q = (2 * n + d) / (2 * d);
      if (neg) begin
         if (q > 64'd2147483648) q = 64'd2147483648;
         return WEIGHT_W'(-longint'(q));
      end
      if (q > 64'd2147483647) q = 64'd2147483647;
      return WEIGHT_W'(q);
   endfunction

   function automatic rsp_type barycentric_weights(req_type r);
      longint abx, aby, acx, acy, pax, pay, ux, uy, uz, mag;
      rsp_type w;
      abx = longint'(r.bx) - r.ax;  aby = longint'(r.by) - r.ay;
      acx = longint'(r.cx) - r.ax;  acy = longint'(r.cy) - r.ay;
      pax = longint'(r.ax) - r.px;  pay = longint'(r.ay) - r.py;
      ux = acx * pay - pax * acy;
      uy = pax * aby - abx * pay;
      uz = abx * acy - acx * aby;
      mag = uz < 0 ? -uz : uz;
      if (mag > longint'(area_thr)) begin
         w.weight_a = q16_quotient(uz - ux - uy, uz);
         w.weight_b = q16_quotient(ux, uz);
         w.weight_c = q16_quotient(uy, uz);
         w.degenerate = 1'b0;
      end else begin
         w.weight_a = NEG_ONE_Q16;
         w.weight_b = ONE_Q16;
         w.weight_c = ONE_Q16;
         w.degenerate = 1'b1;
      end
      return w;
   endfunction

   // receiver stall pattern: phases of free flow, light and heavy stalling
   initial begin
      int mode;
      int left;
      left = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(10, 80);
         end
         left--;
         case (mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (weights_due.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            n_errors++;
         end else begin
            exp_w = weights_due.pop_front();
            n_checked++;
            if (rsp_data.degenerate) n_degen++;
            if (rsp_data.weight_a !== exp_w.weight_a) begin
               $display("%0t: weight_a exp %0d got %0d", $time, exp_w.weight_a,
                        rsp_data.weight_a);
               n_errors++;
            end
            if (rsp_data.weight_b !== exp_w.weight_b) begin
               $display("%0t: weight_b exp %0d got %0d", $time, exp_w.weight_b,
                        rsp_data.weight_b);
               n_errors++;
            end
            if (rsp_data.weight_c !== exp_w.weight_c) begin
               $display("%0t: weight_c exp %0d got %0d", $time, exp_w.weight_c,
                        rsp_data.weight_c);
               n_errors++;
            end
            if (rsp_data.degenerate !== exp_w.degenerate) begin
               $display("%0t: degenerate exp %0b got %0b", $time, exp_w.degenerate,
                        rsp_data.degenerate);
               n_errors++;
            end
         end
      end
   end

   // one request; valid stays high across a burst, gaps between bursts
   task automatic send_request(req_type r);
      if (burst_left == 0) begin
         if (req_valid) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      weights_due.push_back(barycentric_weights(r));
      n_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (weights_due.size() != 0) @(negedge clock);
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] v);
      go_idle();
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en <= 1'b0;
      area_thr = v;
   endtask

   function automatic req_type tri_req(int ax, int ay, int bx, int by, int cx, int cy,
                                       int px, int py);
      req_type r;
      r.ax = 16'(ax); r.ay = 16'(ay); r.bx = 16'(bx); r.by = 16'(by);
      r.cx = 16'(cx); r.cy = 16'(cy); r.px = 16'(px); r.py = 16'(py);
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      endcase
   endfunction

   // corner triangles, degenerate shapes and extreme coordinates
   task automatic test_directed();
      send_request(tri_req(0, 0, 16, 0, 0, 16, 4, 4));
      send_request(tri_req(0, 0, 16, 0, 0, 16, 0, 0));
      send_request(tri_req(0, 0, 0, 16, 16, 0, 16, 16));
      send_request(tri_req(0, 0, 16, 16, 32, 32, 5, 9));
      send_request(tri_req(7, 7, 7, 7, 7, 7, 0, 0));
      send_request(tri_req(0, 0, 1, 0, 0, 3, 0, 0));
      send_request(tri_req(0, 0, 1, 0, 0, 4, 0, 0));
      send_request(tri_req(0, 0, 2, 0, 0, 2, 1, 1));
      send_request(tri_req(0, 0, 1, 0, 0, 4, 32767, -32768));
      send_request(tri_req(0, 0, 2, 0, 0, 2, -32768, 32767));
      send_request(tri_req(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
      send_request(tri_req(32767, 32767, -32768, 32767, 32767, -32768,
                           -32768, -32768));
      send_request(tri_req(-32768, 32767, 32767, 32767, -32768, -32768,
                           32767, -32768));
      send_request(tri_req(-1, -1, -1, -1, -1, -1, -1, -1));
      send_request(tri_req(0, 0, 3, 1, 1, 3, 2, 2));
      send_request(tri_req(0, 0, 1, 1, 2, 2, 3, 4));
      send_request(tri_req(0, 0, 3, 0, 0, 1, -1, 0));
   endtask

   task automatic test_random(int n);
      req_type r;
      int base;
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            r = {$urandom, $urandom, $urandom, $urandom};
         end else if ($urandom_range(0, 9) == 0) begin
            // near-degenerate: tiny or collinear triangle
            base = $signed(16'($urandom));
            r.ax = 16'(base); r.ay = 16'($urandom);
            r.bx = r.ax + 16'($urandom_range(0, 3));
            r.by = r.ay + 16'($urandom_range(0, 3));
            r.cx = r.ax + 16'($urandom_range(0, 3));
            r.cy = r.ay + 16'($urandom_range(0, 3));
            r.px = rand_coord(); r.py = rand_coord();
         end else begin
            r.ax = rand_coord(); r.ay = rand_coord();
            r.bx = rand_coord(); r.by = rand_coord();
            r.cx = rand_coord(); r.cy = rand_coord();
            r.px = rand_coord(); r.py = rand_coord();
         end
         send_request(r);
      end
   endtask

   initial begin
      area_thr = 16'd3;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(120);
      write_threshold(16'd0);
      test_directed();
      test_random(100);
      write_threshold(16'hffff);
      test_directed();
      test_random(80);
      write_threshold(16'd4096);
      test_random(100);
      go_idle();
      $display("tb: %0d requests sent, %0d responses checked, %0d degenerate,",
               n_sent, n_checked, n_degen);
      $display("tb: thresholds 3, 0, 65535 and 4096 exercised");
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bwu_pkg.sv
rtl/bwu_front.sv
rtl/bwu_div_lane.sv
rtl/barycentric_weights_unit.sv
rtl/bwu_checker.sv
dv/tb_barycentric_weights_unit.sv
